// ----- sv/schmitt_and_play_hysteresis_core_defines.svh -----
// assertion macros shared by the hysteresis core
`ifndef SCHMITT_AND_PLAY_HYSTERESIS_CORE_DEFINES_SVH
`define SCHMITT_AND_PLAY_HYSTERESIS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHYST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHYST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/shyst_pkg.sv -----
package shyst_pkg;

    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RADIUS_W   = 31;
    localparam int SMOOTH_W   = 17;
    localparam int RATE_W     = 31;

    // element index modulo by reciprocal: q = (index * recip) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 21;

    // q16.16 one and one half
    localparam logic [SMOOTH_W-1:0] Q16_ONE  = 17'h1_0000;
    localparam int                  Q16_HALF = 32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE           = 3'd0,
        CFG_THRESHOLD_LOW  = 3'd1,
        CFG_THRESHOLD_HIGH = 3'd2,
        CFG_LEVEL_LOW      = 3'd3,
        CFG_LEVEL_HIGH     = 3'd4,
        CFG_PLAY_RADIUS    = 3'd5,
        CFG_SMOOTHING      = 3'd6,
        CFG_RATE_STEP      = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        MODE_SCHMITT = 1'b0,
        MODE_PLAY    = 1'b1
    } hyst_mode_t;

    localparam logic signed [VALUE_W-1:0] RST_THRESHOLD_LOW  = -32'sd32768;
    localparam logic signed [VALUE_W-1:0] RST_THRESHOLD_HIGH = 32'sd32768;
    localparam logic signed [VALUE_W-1:0] RST_LEVEL_LOW      = -32'sd65536;
    localparam logic signed [VALUE_W-1:0] RST_LEVEL_HIGH     = 32'sd65536;
    localparam logic [RADIUS_W-1:0]       RST_PLAY_RADIUS    = 31'd32768;

    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] sample;
        logic                      initialize;
    } item_t;

endpackage

// ----- sv/shyst_if.sv -----
interface shyst_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [shyst_pkg::INDEX_W-1:0]        element_index;
    logic signed [shyst_pkg::VALUE_W-1:0] sample;
    logic                                 initialize;

    modport source (output valid, element_index, sample, initialize, input ready);
    modport sink (input valid, element_index, sample, initialize, output ready);
endinterface

interface shyst_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [shyst_pkg::INDEX_W-1:0]        element_index_out;
    logic signed [shyst_pkg::VALUE_W-1:0] level_out;

    modport source (output valid, element_index_out, level_out, input ready);
    modport sink (input valid, element_index_out, level_out, output ready);
endinterface

interface shyst_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [shyst_pkg::CFG_ADDR_W-1:0] index;
    logic [shyst_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/schmitt_and_play_hysteresis_core.sv -----
// path: a word accepted into a moves through b, c, d and e into the output register
// throughput: one word per cycle while levels is ready; the per-element read-modify-write on the state
//   memory holds a word back while an older word for the same element is still
//   in the three stages between the read and the write-back
// reset: rst_n clears pipeline valids, output valid and all config registers;
//   the state memory is not cleared, an element is defined once written or seeded
`include "schmitt_and_play_hysteresis_core_defines.svh"

module schmitt_and_play_hysteresis_core #(
    parameter int unsigned ELEMENTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    shyst_in_if.sink    samples,
    shyst_out_if.source levels,
    shyst_cfg_if.sink   cfg
);

    localparam int W       = shyst_pkg::VALUE_W;
    localparam int XW      = W + 2;                             // headroom for sums
    localparam int IW      = shyst_pkg::INDEX_W;
    localparam int ADDR_W  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int REM_W   = (ADDR_W > IW) ? ADDR_W : IW;
    localparam int RECIP   = ((2 ** shyst_pkg::RECIP_SHIFT) + ELEMENTS - 1) / ELEMENTS;
    localparam int QPROD_W = shyst_pkg::RECIP_SHIFT + IW + 1;
    localparam int EPROD_W = IW + 17;                           // quotient times depth
    localparam int PROD_W  = shyst_pkg::SMOOTH_W + 1 + XW;      // smoothing product

    // ------------------------------------------------------------------
    // configuration registers, always ready
    // ------------------------------------------------------------------
    shyst_pkg::hyst_mode_t                  mode_reg;
    logic signed [W-1:0]                    thr_lo_reg;
    logic signed [W-1:0]                    thr_hi_reg;
    logic signed [W-1:0]                    lvl_lo_reg;
    logic signed [W-1:0]                    lvl_hi_reg;
    logic [shyst_pkg::RADIUS_W-1:0]         radius_reg;
    logic [shyst_pkg::SMOOTH_W-1:0]         smooth_reg;
    logic [shyst_pkg::RATE_W-1:0]           rate_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= shyst_pkg::MODE_SCHMITT;
            thr_lo_reg <= shyst_pkg::RST_THRESHOLD_LOW;
            thr_hi_reg <= shyst_pkg::RST_THRESHOLD_HIGH;
            lvl_lo_reg <= shyst_pkg::RST_LEVEL_LOW;
            lvl_hi_reg <= shyst_pkg::RST_LEVEL_HIGH;
            radius_reg <= shyst_pkg::RST_PLAY_RADIUS;
            smooth_reg <= '0;
            rate_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (shyst_pkg::cfg_reg_t'(cfg.index))
                shyst_pkg::CFG_MODE:           mode_reg   <= shyst_pkg::hyst_mode_t'(cfg.data[0]);
                shyst_pkg::CFG_THRESHOLD_LOW:  thr_lo_reg <= cfg.data;
                shyst_pkg::CFG_THRESHOLD_HIGH: thr_hi_reg <= cfg.data;
                shyst_pkg::CFG_LEVEL_LOW:      lvl_lo_reg <= cfg.data;
                shyst_pkg::CFG_LEVEL_HIGH:     lvl_hi_reg <= cfg.data;
                shyst_pkg::CFG_PLAY_RADIUS:    radius_reg <= cfg.data[shyst_pkg::RADIUS_W-1:0];
                shyst_pkg::CFG_SMOOTHING:      smooth_reg <= cfg.data[shyst_pkg::SMOOTH_W-1:0];
                shyst_pkg::CFG_RATE_STEP:      rate_reg   <= cfg.data[shyst_pkg::RATE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    //   a: input word, quotient of index by depth
    //   b: slot = index - quotient * depth, memory read issued
    //   c: read data back, seeding, schmitt / play step
    //   d: smoothing product
    //   e: rounding, rate limit, write-back and load of the output register
    // ------------------------------------------------------------------
    logic                 a_valid_reg, a_valid_next;
    logic                 b_valid_reg, b_valid_next;
    logic                 c_valid_reg, d_valid_reg, e_valid_reg;
    logic                 out_valid_reg;
    shyst_pkg::item_t     a_item_reg, b_item_reg, c_item_reg;
    logic [IW-1:0]        b_quot_reg;
    logic [ADDR_W-1:0]    c_slot_reg, d_slot_reg, e_slot_reg;
    logic [IW-1:0]        d_index_reg, e_index_reg;
    logic signed [W-1:0]  d_y_reg, d_prev_reg, e_y_reg, e_prev_reg;
    logic signed [PROD_W-1:0] e_prod_reg;
    logic [IW-1:0]        out_index_reg;
    logic signed [W-1:0]  out_level_reg;

    logic                 pipe_go;   // stages c..e and the output register move
    logic                 hazard;    // slot in b still has a write-back pending
    logic                 b_go;      // b moves into c and issues its read
    logic                 b_load;    // b takes the word in a
    logic                 a_load;    // a takes a new input word

    logic [ADDR_W-1:0]    b_slot;
    logic                 rd_en, wr_en;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic signed [W-1:0]  wr_data;
    logic signed [W-1:0]  rd_data_reg;

    assign pipe_go = !out_valid_reg || levels.ready;
    assign hazard  = (c_valid_reg && (c_slot_reg == b_slot))
                  || (d_valid_reg && (d_slot_reg == b_slot))
                  || (e_valid_reg && (e_slot_reg == b_slot));
    assign b_go    = b_valid_reg && pipe_go && !hazard;
    assign b_load  = !b_valid_reg || b_go;
    assign a_load  = !a_valid_reg || b_load;

    assign samples.ready = a_load;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (b_load)
        begin
            b_valid_next = a_valid_reg;
        end
        if (a_load)
        begin
            a_valid_next = samples.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            if (pipe_go)
            begin
                c_valid_reg   <= b_go;
                d_valid_reg   <= c_valid_reg;
                e_valid_reg   <= d_valid_reg;
                out_valid_reg <= e_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage a: quotient by reciprocal multiply (exact for 10-bit indexes)
    // ------------------------------------------------------------------
    logic [QPROD_W-1:0] a_qprod;

    assign a_qprod = QPROD_W'(a_item_reg.index) * QPROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_item_reg.index      <= samples.element_index;
            a_item_reg.sample     <= samples.sample;
            a_item_reg.initialize <= samples.initialize;
        end
        if (b_load)
        begin
            b_item_reg <= a_item_reg;
            b_quot_reg <= a_qprod[shyst_pkg::RECIP_SHIFT +: IW];
        end
    end

    // ------------------------------------------------------------------
    // stage b: remainder gives the memory slot
    // ------------------------------------------------------------------
    logic [EPROD_W-1:0] b_eprod;
    logic [IW-1:0]      b_rem;
    logic [REM_W-1:0]   b_rem_wide;

    assign b_eprod    = EPROD_W'(b_quot_reg) * EPROD_W'(ELEMENTS);
    assign b_rem      = b_item_reg.index - b_eprod[IW-1:0];
    assign b_rem_wide = REM_W'(b_rem);
    assign b_slot     = b_rem_wide[ADDR_W-1:0];

    assign rd_en   = b_go;
    assign rd_addr = b_slot;

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            c_item_reg <= b_item_reg;
            c_slot_reg <= b_slot;
        end
    end

    // ------------------------------------------------------------------
    // state memory: one write port at e, one registered read port at b
    // ------------------------------------------------------------------
    logic [W-1:0] mem [ELEMENTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // saturate a widened value back to the value width
    function automatic logic signed [W-1:0] sat_value(input logic signed [XW-1:0] v);
        logic [XW-W:0] top;
        top = v[XW-1:W-1];
        if ((&top) || !(|top))
        begin
            sat_value = v[W-1:0];
        end
        else if (v[XW-1])
        begin
            sat_value = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // stage c: seed or read last output, then schmitt or play step
    // ------------------------------------------------------------------
    logic signed [W-1:0]  c_prev;
    logic signed [W-1:0]  c_y;
    logic signed [XW-1:0] c_x_x, c_prev_x, c_radius_x, c_twice_prev, c_mid_sum;
    logic signed [XW-1:0] c_up, c_down;

    always_comb
    begin
        if (c_item_reg.initialize)
        begin
            if (mode_reg == shyst_pkg::MODE_PLAY)
            begin
                c_prev = c_item_reg.sample;
            end
            else
            begin
                c_prev = (c_item_reg.sample >= thr_hi_reg) ? lvl_hi_reg : lvl_lo_reg;
            end
        end
        else
        begin
            c_prev = rd_data_reg;
        end
    end

    assign c_x_x        = XW'(c_item_reg.sample);
    assign c_prev_x     = XW'(c_prev);
    assign c_radius_x   = $signed(XW'(radius_reg));
    assign c_twice_prev = c_prev_x <<< 1;
    assign c_mid_sum    = XW'(lvl_lo_reg) + XW'(lvl_hi_reg);
    assign c_up         = c_x_x - c_prev_x;
    assign c_down       = c_prev_x - c_x_x;

    always_comb
    begin
        if (mode_reg == shyst_pkg::MODE_SCHMITT)
        begin
            // upper branch falls only at or below the low threshold
            if (c_twice_prev >= c_mid_sum)
            begin
                c_y = (c_item_reg.sample <= thr_lo_reg) ? lvl_lo_reg : lvl_hi_reg;
            end
            else
            begin
                c_y = (c_item_reg.sample >= thr_hi_reg) ? lvl_hi_reg : lvl_lo_reg;
            end
        end
        else
        begin
            priority if (c_up > c_radius_x)
            begin
                c_y = sat_value(c_x_x - c_radius_x);
            end
            else if (c_down > c_radius_x)
            begin
                c_y = sat_value(c_x_x + c_radius_x);
            end
            else
            begin
                c_y = c_prev;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_go)
        begin
            d_index_reg <= c_item_reg.index;
            d_slot_reg  <= c_slot_reg;
            d_y_reg     <= c_y;
            d_prev_reg  <= c_prev;
        end
    end

    // ------------------------------------------------------------------
    // stage d: s * (prev - y), which is zero with smoothing off
    // ------------------------------------------------------------------
    logic [shyst_pkg::SMOOTH_W-1:0]       d_s_eff;
    logic signed [shyst_pkg::SMOOTH_W:0]  d_s_signed;
    logic signed [XW-1:0]                 d_diff;
    logic signed [PROD_W-1:0]             d_prod;

    assign d_s_eff    = (smooth_reg > shyst_pkg::Q16_ONE) ? shyst_pkg::Q16_ONE : smooth_reg;
    assign d_s_signed = $signed({1'b0, d_s_eff});
    assign d_diff     = XW'(d_prev_reg) - XW'(d_y_reg);
    assign d_prod     = PROD_W'(d_s_signed) * PROD_W'(d_diff);

    always_ff @(posedge clk)
    begin
        if (pipe_go)
        begin
            e_index_reg <= d_index_reg;
            e_slot_reg  <= d_slot_reg;
            e_y_reg     <= d_y_reg;
            e_prev_reg  <= d_prev_reg;
            e_prod_reg  <= d_prod;
        end
    end

    // ------------------------------------------------------------------
    // stage e: round half up, rate limit, write back
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] e_adj_full;
    logic signed [XW-1:0]     e_smoothed, e_delta, e_rate_x, e_limited;

    assign e_adj_full = (e_prod_reg + PROD_W'(shyst_pkg::Q16_HALF)) >>> 16;
    assign e_smoothed = XW'(e_y_reg) + e_adj_full[XW-1:0];
    assign e_rate_x   = $signed(XW'(rate_reg));

    always_comb
    begin
        e_delta = e_smoothed - XW'(e_prev_reg);
        if (rate_reg != '0)
        begin
            priority if (e_delta > e_rate_x)
            begin
                e_delta = e_rate_x;
            end
            else if (e_delta < -e_rate_x)
            begin
                e_delta = -e_rate_x;
            end
        end
        e_limited = XW'(e_prev_reg) + e_delta;
    end

    assign wr_en   = e_valid_reg && pipe_go;
    assign wr_addr = e_slot_reg;
    assign wr_data = sat_value(e_limited);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_index_reg <= e_index_reg;
            out_level_reg <= wr_data;
        end
    end

    assign levels.valid             = out_valid_reg;
    assign levels.element_index_out = out_index_reg;
    assign levels.level_out         = out_level_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SHYST_ASSERT_NOW(a_rd_wr_same_slot, rd_en && wr_en, rd_addr != wr_addr, "read and write-back hit one slot")
    `SHYST_ASSERT_NOW(a_cd_slot_clash, c_valid_reg && d_valid_reg, c_slot_reg != d_slot_reg, "slot in c also in d")
    `SHYST_ASSERT_NOW(a_ce_slot_clash, c_valid_reg && e_valid_reg, c_slot_reg != e_slot_reg, "slot in c also in e")
    `SHYST_ASSERT_NEXT(a_wr_loads_out, wr_en, out_valid_reg, "write-back without output word")

endmodule

// ----- dv/hysteresis_level_checker.sv -----
`timescale 1ns / 100ps

module hysteresis_level_checker #(
    parameter int unsigned ELEMENTS = 1024
) (
    input  logic  clk,
    input  logic  rst_n,
    shyst_in_if   samples,
    shyst_out_if  levels,
    shyst_cfg_if  cfg,
    output int    failures,
    output int    pending
);
    import shyst_pkg::*;

    localparam longint VMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint VMIN = -VMAX - 1;
    localparam longint ONE  = 65536;

    typedef struct {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] level;
    } level_word_t;

    // shadow of the register file
    hyst_mode_t                mode;
    logic signed [VALUE_W-1:0] thr_lo;
    logic signed [VALUE_W-1:0] thr_hi;
    logic signed [VALUE_W-1:0] lvl_lo;
    logic signed [VALUE_W-1:0] lvl_hi;
    logic [RADIUS_W-1:0]       radius;
    logic [SMOOTH_W-1:0]       smooth;
    logic [RATE_W-1:0]         rate;

    // last output per element, never cleared
    logic signed [VALUE_W-1:0] last_level [ELEMENTS];

    level_word_t               predicted_levels [$];
    level_word_t               oldest;
    level_word_t               fresh;
    int unsigned               slot;
    int                        error_count = 0;

    function automatic logic signed [VALUE_W-1:0] next_level(
        logic signed [VALUE_W-1:0] sample,
        logic                      init,
        logic signed [VALUE_W-1:0] stored
    );
        longint x, prev, y, s, d, r, lim;
        x   = sample;
        r   = radius;
        lim = rate;
        if (init)
            prev = (mode == MODE_SCHMITT) ? ((x >= thr_hi) ? lvl_hi : lvl_lo) : x;
        else
            prev = stored;

        if (mode == MODE_SCHMITT) begin
            if (2 * prev >= longint'(lvl_lo) + longint'(lvl_hi))
                y = (x <= thr_lo) ? lvl_lo : lvl_hi;
            else
                y = (x >= thr_hi) ? lvl_hi : lvl_lo;
        end else begin
            if (x - prev > r)
                y = x - r;
            else if (prev - x > r)
                y = x + r;
            else
                y = prev;
        end

        // weight of the old output, saturating at one
        if (smooth != '0) begin
            s = (smooth > Q16_ONE) ? ONE : longint'(smooth);
            y = ((ONE - s) * y + s * prev + Q16_HALF) >>> 16;
        end

        if (lim != 0) begin
            d = y - prev;
            if (d > lim)
                d = lim;
            else if (d < -lim)
                d = -lim;
            y = prev + d;
        end

        if (y > VMAX)
            y = VMAX;
        if (y < VMIN)
            y = VMIN;
        return y[VALUE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode   = MODE_SCHMITT;
            thr_lo = RST_THRESHOLD_LOW;
            thr_hi = RST_THRESHOLD_HIGH;
            lvl_lo = RST_LEVEL_LOW;
            lvl_hi = RST_LEVEL_HIGH;
            radius = RST_PLAY_RADIUS;
            smooth = '0;
            rate   = '0;
            predicted_levels.delete();
        end
        else
        begin
            if (levels.valid && levels.ready)
            begin
                if (predicted_levels.size() == 0)
                begin
                    $error("level word with no prediction: element_index_out %0d level_out %0d",
                           levels.element_index_out, levels.level_out);
                    error_count++;
                end
                else
                begin
                    oldest = predicted_levels.pop_front();
                    if (levels.element_index_out !== oldest.index)
                    begin
                        $error("element_index_out mismatch: expected %0d, actual %0d",
                               oldest.index, levels.element_index_out);
                        error_count++;
                    end
                    if (levels.level_out !== oldest.level)
                    begin
                        $error("level_out mismatch: expected %0d, actual %0d",
                               oldest.level, levels.level_out);
                        error_count++;
                    end
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    CFG_MODE:           mode   = hyst_mode_t'(cfg.data[0]);
                    CFG_THRESHOLD_LOW:  thr_lo = cfg.data;
                    CFG_THRESHOLD_HIGH: thr_hi = cfg.data;
                    CFG_LEVEL_LOW:      lvl_lo = cfg.data;
                    CFG_LEVEL_HIGH:     lvl_hi = cfg.data;
                    CFG_PLAY_RADIUS:    radius = cfg.data[RADIUS_W-1:0];
                    CFG_SMOOTHING:      smooth = cfg.data[SMOOTH_W-1:0];
                    CFG_RATE_STEP:      rate   = cfg.data[RATE_W-1:0];
                    default:            ;
                endcase
            end

            if (samples.valid && samples.ready)
            begin
                slot            = samples.element_index % ELEMENTS;
                fresh.index     = samples.element_index;
                fresh.level     = next_level(samples.sample, samples.initialize,
                                             last_level[slot]);
                last_level[slot] = fresh.level;
                predicted_levels.push_back(fresh);
            end
        end
        failures <= error_count;
        pending  <= predicted_levels.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import shyst_pkg::*;

    localparam int unsigned ELEMENTS      = 1024;
    // far above the slowest legal run of ~1100 words with stalls and gaps
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_PHASES = 12;
    localparam int          WORDS_PER_PHASE = 85;
    localparam int          DRAIN_CYCLES  = 20;

    logic clk;
    logic rst_n;

    shyst_in_if  samples ();
    shyst_out_if levels ();
    shyst_cfg_if cfg ();

    int failures;
    int pending;
    int cycle_count = 0;

    // no idling on either side while set
    bit calm = 1'b0;

    // elements written at least once, so that a plain step never reads garbage
    bit seeded [ELEMENTS];

    // register copies that only steer the choice of samples
    logic signed [VALUE_W-1:0] thr_lo_shadow = RST_THRESHOLD_LOW;
    logic signed [VALUE_W-1:0] thr_hi_shadow = RST_THRESHOLD_HIGH;
    logic [RADIUS_W-1:0]       radius_shadow = RST_PLAY_RADIUS;

    schmitt_and_play_hysteresis_core #(
        .ELEMENTS (ELEMENTS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .levels  (levels),
        .cfg     (cfg)
    );

    hysteresis_level_checker #(
        .ELEMENTS (ELEMENTS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .levels   (levels),
        .cfg      (cfg),
        .failures (failures),
        .pending  (pending)
    );

    // clock, period 8 ns
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("schmitt_and_play_hysteresis_core verification failed");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge only
    initial levels.ready = 1'b0;
    always @(negedge clk)
        levels.ready <= rst_n && (calm || $urandom_range(99) >= 32);

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 32);
    endfunction

    // one word on the sample channel; called and left at a falling edge,
    // valid stays high into the next word so it is never dropped and raised at once
    task automatic push_sample(logic [INDEX_W-1:0] index, logic signed [VALUE_W-1:0] value,
                               logic init);
        while (take_break())
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid         <= 1'b1;
        samples.element_index <= index;
        samples.sample        <= value;
        samples.initialize    <= init;
        seeded[index] = 1'b1;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write, same calling convention as push_sample
    task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= which;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        case (which)
            CFG_THRESHOLD_LOW:  thr_lo_shadow = value;
            CFG_THRESHOLD_HIGH: thr_hi_shadow = value;
            CFG_PLAY_RADIUS:    radius_shadow = value[RADIUS_W-1:0];
            default:            ;
        endcase
    endtask

    // q16.16 value: extremes, a few units around zero, or anything
    function automatic logic signed [VALUE_W-1:0] pick_q16();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            case (r % 4)
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        if (r < 70)
            return int'($urandom_range(8 * 65536)) - 262144;
        return $urandom;
    endfunction

    // sample aimed at the interesting spots of the current setup
    function automatic logic signed [VALUE_W-1:0] pick_sample();
        int unsigned r;
        int          k;
        r = $urandom_range(99);
        k = int'($urandom_range(4)) - 2;
        if (r < 20)
            return $urandom;
        if (r < 55)
            return int'($urandom_range(8 * 65536)) - 262144;
        // right on and beside the thresholds
        if (r < 75)
            return ((r % 2) ? thr_lo_shadow : thr_hi_shadow) + k;
        if (r < 85)
            return pick_q16();
        // about one play radius away from zero
        return ((r % 2) ? int'(radius_shadow) : -int'(radius_shadow)) + k;
    endfunction

    // random setup: each register rewritten now and then, masked registers with junk above
    task automatic randomize_setup();
        cfg_reg_t               which;
        logic [CFG_DATA_W-1:0]  value;
        logic [CFG_DATA_W-1:0]  mask;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        int unsigned            r;
        which = which.first();
        do
        begin
            if ($urandom_range(99) < 60)
            begin
                r    = $urandom_range(99);
                mask = '1;
                case (which)
                    CFG_MODE:
                    begin
                        value = (r < 50) ? MODE_SCHMITT : MODE_PLAY;
                        mask  = 32'h0000_0001;
                    end
                    CFG_THRESHOLD_LOW, CFG_LEVEL_LOW:
                    begin
                        // thresholds mostly ordered against the partner register, levels against a fresh pick
                        lo = pick_q16();
                        hi = (which == CFG_THRESHOLD_LOW) ? thr_hi_shadow : pick_q16();
                        if (r < 80 && lo > hi)
                            lo = hi - 1;
                        value = lo;
                    end
                    CFG_THRESHOLD_HIGH, CFG_LEVEL_HIGH:
                    begin
                        hi = pick_q16();
                        lo = (which == CFG_THRESHOLD_HIGH) ? thr_lo_shadow : pick_q16();
                        if (r < 80 && hi < lo)
                            hi = lo + 1;
                        value = hi;
                    end
                    CFG_PLAY_RADIUS:
                    begin
                        if (r < 10)
                            value = 0;
                        else if (r < 20)
                            value = 32'h7FFF_FFFF;
                        else if (r < 70)
                            value = $urandom_range(4 * 65536, 1);
                        else
                            value = $urandom;
                        mask = 32'h7FFF_FFFF;
                    end
                    CFG_SMOOTHING:
                    begin
                        if (r < 40)
                            value = 0;
                        else if (r < 50)
                            value = 65536;
                        // above one holds the output
                        else if (r < 60)
                            value = $urandom_range(131071, 65537);
                        else
                            value = $urandom_range(65535, 1);
                        mask = 32'h0001_FFFF;
                    end
                    default:
                    begin
                        if (r < 40)
                            value = 0;
                        else if (r < 50)
                            value = 32'h7FFF_FFFF;
                        else if (r < 80)
                            value = $urandom_range(2 * 65536, 1);
                        else
                            value = $urandom;
                        mask = 32'h7FFF_FFFF;
                    end
                endcase
                if ($urandom_range(99) < 30)
                    value = (value & mask) | ($urandom & ~mask);
                write_reg(which, value);
            end
            which = which.next();
        end
        while (which != which.first());
        cfg.valid <= 1'b0;
    endtask

    // well-formed traffic: hot elements to hit the read-modify-write hazard,
    // every unseeded element seeded on first touch
    task automatic random_word();
        logic [INDEX_W-1:0] index;
        int unsigned        r;
        logic               init;
        r = $urandom_range(7);
        if ($urandom_range(99) < 45)
            index = (r < 4) ? r : ELEMENTS - 8 + r;
        else
            index = $urandom_range(ELEMENTS - 1);
        init = !seeded[index] || ($urandom_range(99) < 8);
        push_sample(index, pick_sample(), init);
    endtask

    // close a phase: lower valid and let every predicted word come back
    task automatic settle();
        samples.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        // all inputs known from time zero
        rst_n                 = 1'b0;
        samples.valid         = 1'b0;
        samples.element_index = '0;
        samples.sample        = '0;
        samples.initialize    = 1'b0;
        cfg.valid             = 1'b0;
        cfg.index             = CFG_MODE;
        cfg.data              = '0;
        foreach (seeded[i])
            seeded[i] = 1'b0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // schmitt mode on reset values: seeding both ways, thresholds hit exactly
        push_sample(10'd0,    32'sh8000_0000, 1'b1);
        push_sample(10'd1023, 32'sh7FFF_FFFF, 1'b1);
        push_sample(10'd0,    32'sd32768,     1'b0);
        push_sample(10'd0,    -32'sd32768,    1'b0);
        push_sample(10'd0,    -32'sd32767,    1'b0);
        push_sample(10'd1023, -32'sd32767,    1'b0);
        push_sample(10'd1023, -32'sd32768,    1'b0);
        push_sample(10'd5,    32'sd32767,     1'b1);
        settle();

        // play mode, widest radius, thresholds and levels disordered
        write_reg(CFG_MODE,           MODE_PLAY);
        write_reg(CFG_THRESHOLD_LOW,  32'h7FFF_FFFF);
        write_reg(CFG_THRESHOLD_HIGH, 32'h8000_0000);
        write_reg(CFG_LEVEL_LOW,      32'h7FFF_FFFF);
        write_reg(CFG_LEVEL_HIGH,     32'h8000_0000);
        write_reg(CFG_PLAY_RADIUS,    32'h7FFF_FFFF);
        write_reg(CFG_SMOOTHING,      32'h0000_0000);
        write_reg(CFG_RATE_STEP,      32'h0000_0000);
        cfg.valid <= 1'b0;
        push_sample(10'd2, 32'sh7FFF_FFFF, 1'b1);
        push_sample(10'd2, 32'sh8000_0000, 1'b0);
        push_sample(10'd2, 32'sh7FFF_FFFF, 1'b0);
        push_sample(10'd3, 32'sh0000_0000, 1'b1);
        push_sample(10'd3, 32'sh7FFF_FFFF, 1'b0);
        push_sample(10'd3, 32'sh8000_0000, 1'b0);
        settle();

        // zero radius follows the sample, then half smoothing and a one-unit rate limit
        write_reg(CFG_PLAY_RADIUS, 32'h0000_0000);
        write_reg(CFG_SMOOTHING,   32'h0000_8000);
        write_reg(CFG_RATE_STEP,   32'h0001_0000);
        cfg.valid <= 1'b0;
        push_sample(10'd4, 32'sd1000,       1'b1);
        push_sample(10'd4, 32'sh7FFF_FFFF,  1'b0);
        push_sample(10'd4, 32'sh8000_0000,  1'b0);
        push_sample(10'd6, -32'sd70000,     1'b1);
        push_sample(10'd6, -32'sd70000,     1'b0);
        settle();

        // schmitt mode with smoothing above one, which holds the output
        write_reg(CFG_MODE,      MODE_SCHMITT);
        write_reg(CFG_SMOOTHING, 32'h0001_FFFF);
        write_reg(CFG_RATE_STEP, 32'h0000_0000);
        cfg.valid <= 1'b0;
        push_sample(10'd7,    32'sh7FFF_FFFF, 1'b1);
        push_sample(10'd7,    32'sh8000_0000, 1'b0);
        push_sample(10'd1023, 32'sh0000_0000, 1'b0);
        settle();

        // random phases, two of them with both sides running flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calm = (phase == 4 || phase == 9);
            randomize_setup();
            repeat (WORDS_PER_PHASE)
                random_word();
            settle();
        end
        calm = 1'b0;

        // let any stray word surface before the verdict
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("schmitt_and_play_hysteresis_core verification clean");
        else
            $display("schmitt_and_play_hysteresis_core verification failed");
        $finish;
    end

endmodule

// ----- schmitt_and_play_hysteresis_core.f -----
+incdir+sv
sv/shyst_pkg.sv
sv/shyst_if.sv
sv/schmitt_and_play_hysteresis_core.sv
dv/hysteresis_level_checker.sv
dv/testbench.sv
